// ===== rtl/core/pixel_color_grade_unit_defines.svh =====
// Assertion macros for the pixel colour grading unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef PIXEL_COLOR_GRADE_UNIT_DEFINES_SVH
`define PIXEL_COLOR_GRADE_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset
`define PCG_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pixel_color_grade_unit: invariant violated");

// Antecedent implies consequent in the same cycle
`define PCG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_color_grade_unit: same-cycle check failed");

// Antecedent implies consequent in the next cycle
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_color_grade_unit: next-cycle check failed");

`endif

// ===== rtl/core/pcg_pkg.sv =====
// Types, fixed-point constants and gain helpers for the pixel colour grading unit.
// Standalone package; used by pixel_color_grade_unit.
package pcg_pkg;

    typedef logic [7:0]  t_chan;
    typedef logic [16:0] t_gain;
    typedef logic [23:0] t_luma;
    typedef logic [40:0] t_prod;
    typedef logic [14:0] t_term;
    typedef logic [1:0]  t_kind;

    // Unity in Q1.16 and the reset strength (0.5)
    localparam t_gain ONE_Q16      = 17'd65536;
    localparam t_gain STRENGTH_RST = 17'd32768;

    // Luma weights, Q0.16, summing to exactly 1.0
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    // Gain coefficients, Q0.16
    localparam t_term K_0_10 = 15'd6554;
    localparam t_term K_0_15 = 15'd9830;
    localparam t_term K_0_20 = 15'd13107;
    localparam t_term K_0_30 = 15'd19661;

    // Rounding bias for the gain term
    localparam logic [31:0] ROUND_HALF = 32'd32768;

    // Luma above half scale: 2*L > 255*65536, i.e. L > 8355840
    localparam t_luma HALF_LUMA_THR = 24'd8355840;

    // Register indexes
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_STRENGTH = 2'd1;

    // Grade modes
    localparam logic [2:0] MODE_PASS    = 3'd0;
    localparam logic [2:0] MODE_COOL    = 3'd1;
    localparam logic [2:0] MODE_WARM    = 3'd2;
    localparam logic [2:0] MODE_TEAL    = 3'd3;
    localparam logic [2:0] MODE_MONO    = 3'd4;
    localparam logic [2:0] MODE_VINTAGE = 3'd5;

    // How the multiplier output is finished
    localparam t_kind KIND_SCALE = 2'd0;  // (c * gain) >> 16
    localparam t_kind KIND_BLEND = 2'd1;  // (c * keep * 2^16 + L * s) >> 32
    localparam t_kind KIND_LUMA  = 2'd2;  // (L * gain) >> 32

    // Clamp strength to 1.0
    function automatic t_gain eff_strength(input t_gain s);
        return (s > ONE_Q16) ? ONE_Q16 : s;
    endfunction

    // Rounded gain term (s * k + 0.5) >> 16
    function automatic t_term gain_term(input t_gain s, input t_term k);
        logic [31:0] prod;
        prod = 32'(s) * 32'(k) + ROUND_HALF;
        return prod[30:16];
    endfunction

endpackage

// ===== rtl/core/pixel_color_grade_unit.sv =====
// Pixel colour grading unit: four register stages (capture, luma, multiply, finish).
// Throughput: one pixel per clock while the output is not stalled, set by the
// single multiply stage per channel.
// Each stage holds while its successor is full, so stalls lose and repeat nothing.
// Synchronous active-low reset empties the pipe, sets mode to pass and strength to 0.5.
// Depends on pcg_pkg and pixel_color_grade_unit_defines.svh.
`include "pixel_color_grade_unit_defines.svh"

module pixel_color_grade_unit
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input pixel stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // red_in, green_in, blue_in, alpha_in
    // output pixel stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // red_out, green_out, blue_out, alpha_out
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    // Configuration registers
    logic [2:0] r_mode, n_mode;
    t_gain      r_strength, n_strength;

    // Strength-derived gains
    t_gain n_s_eff;
    t_gain r_s_eff, r_keep;
    t_gain r_up10, r_up15, r_up20, r_up30, r_dn10, r_dn20;

    // Pipeline control
    logic [3:0] r_vld;
    logic [3:0] w_ld;

    // Stage payloads
    t_chan r_s0_ch [3];
    t_chan r_s0_a;
    t_chan r_s1_ch [3];
    t_chan r_s1_a;
    t_luma r_s1_lum;
    t_prod r_s2_prod [3];
    t_prod r_s2_mix;
    t_kind r_s2_kind;
    t_chan r_s2_a;
    logic [31:0] r_s3_data;

    // Combinational values
    t_luma w_lum;
    logic  w_bright;
    t_kind w_kind;
    t_gain w_gain [3];
    t_luma w_op   [3];
    logic [25:0] w_sum [3];
    t_chan w_res  [3];

    assign o_cfg_ready = 1'b1;

    // Decode configuration writes; reset folds in so derived gains track it
    always_comb begin
        n_mode     = r_mode;
        n_strength = r_strength;
        if (!i_rst_n) begin
            n_mode     = MODE_PASS;
            n_strength = STRENGTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:     n_mode     = i_cfg_data[2:0];
                REG_STRENGTH: n_strength = i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PASS;
            r_strength <= STRENGTH_RST;
        end else begin
            r_mode     <= n_mode;
            r_strength <= n_strength;
        end
    end

    // Precompute channel gains from the strength
    assign n_s_eff = eff_strength(n_strength);

    always_ff @(posedge i_clk) begin
        r_s_eff <= n_s_eff;
        r_keep  <= ONE_Q16 - n_s_eff;
        r_up10  <= ONE_Q16 + 17'(gain_term(n_s_eff, K_0_10));
        r_up15  <= ONE_Q16 + 17'(gain_term(n_s_eff, K_0_15));
        r_up20  <= ONE_Q16 + 17'(gain_term(n_s_eff, K_0_20));
        r_up30  <= ONE_Q16 + 17'(gain_term(n_s_eff, K_0_30));
        r_dn10  <= ONE_Q16 - 17'(gain_term(n_s_eff, K_0_10));
        r_dn20  <= ONE_Q16 - 17'(gain_term(n_s_eff, K_0_20));
    end

    // Each stage loads when empty or when its successor moves on
    assign w_ld[3] = !r_vld[3] || i_m_tready;
    assign w_ld[2] = !r_vld[2] || w_ld[3];
    assign w_ld[1] = !r_vld[1] || w_ld[2];
    assign w_ld[0] = !r_vld[0] || w_ld[1];

    assign o_s_tready = w_ld[0];
    assign o_m_tvalid = r_vld[3];
    assign o_m_tdata  = r_s3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) r_vld[0] <= i_s_tvalid;
            if (w_ld[1]) r_vld[1] <= r_vld[0];
            if (w_ld[2]) r_vld[2] <= r_vld[1];
            if (w_ld[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Stage 0: capture the input word
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s0_ch[0] <= i_s_tdata[7:0];
            r_s0_ch[1] <= i_s_tdata[15:8];
            r_s0_ch[2] <= i_s_tdata[23:16];
            r_s0_a     <= i_s_tdata[31:24];
        end
    end

    // Stage 1: luma in Q8.16
    assign w_lum = 24'(r_s0_ch[0]) * 24'(LUMA_WR)
                 + 24'(r_s0_ch[1]) * 24'(LUMA_WG)
                 + 24'(r_s0_ch[2]) * 24'(LUMA_WB);

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_s1_ch  <= r_s0_ch;
            r_s1_a   <= r_s0_a;
            r_s1_lum <= w_lum;
        end
    end

    // Stage 2: pick operand and gain per channel by mode
    assign w_bright = r_s1_lum > HALF_LUMA_THR;

    always_comb begin
        w_kind    = KIND_SCALE;
        w_gain[0] = ONE_Q16;
        w_gain[1] = ONE_Q16;
        w_gain[2] = ONE_Q16;
        unique case (r_mode)
            MODE_COOL: begin
                w_gain[0] = r_dn20;
                w_gain[2] = r_up30;
            end
            MODE_WARM: begin
                w_gain[0] = r_up30;
                w_gain[1] = r_up10;
                w_gain[2] = r_dn20;
            end
            MODE_TEAL: begin
                if (w_bright) begin
                    w_gain[0] = r_up20;
                    w_gain[1] = r_up10;
                end else begin
                    w_gain[1] = r_up20;
                    w_gain[2] = r_up20;
                end
            end
            MODE_MONO: begin
                w_kind    = KIND_BLEND;
                w_gain[0] = r_keep;
                w_gain[1] = r_keep;
                w_gain[2] = r_keep;
            end
            MODE_VINTAGE: begin
                w_kind    = KIND_LUMA;
                w_gain[0] = r_up30;
                w_gain[1] = r_up15;
                w_gain[2] = r_dn10;
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            w_op[i] = (w_kind == KIND_LUMA) ? r_s1_lum : 24'(r_s1_ch[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_prod[i] <= 41'(w_op[i]) * 41'(w_gain[i]);
            end
            r_s2_mix  <= 41'(r_s1_lum) * 41'(r_s_eff);
            r_s2_kind <= w_kind;
            r_s2_a    <= r_s1_a;
        end
    end

    // Stage 3: shift, blend and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // floor((P*2^16 + M) / 2^32) == floor((P + floor(M/2^16)) / 2^16)
            w_sum[i] = 26'(r_s2_prod[i][24:0]) + 26'(r_s2_mix[40:16]);
            case (r_s2_kind)
                KIND_BLEND:
                    w_res[i] = (w_sum[i][25:24] != 2'b00) ? 8'hFF : w_sum[i][23:16];
                KIND_LUMA:
                    w_res[i] = (r_s2_prod[i][40] != 1'b0) ? 8'hFF : r_s2_prod[i][39:32];
                default:
                    w_res[i] = (r_s2_prod[i][40:24] != '0) ? 8'hFF : r_s2_prod[i][23:16];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_s3_data <= {r_s2_a, w_res[2], w_res[1], w_res[0]};
        end
    end

    // Checks
    `PCG_ASSERT_ALWAYS(a_keep_plus_strength, i_clk, i_rst_n, (r_keep + r_s_eff) == ONE_Q16)
    `PCG_ASSERT_NEXT(a_accept_fills_stage0, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0])
    `PCG_ASSERT_NEXT(a_blocked_stage_holds, i_clk, i_rst_n, r_vld[2] && !w_ld[3], r_vld[2])
    `PCG_ASSERT_SAME(a_blend_in_range, i_clk, i_rst_n, r_vld[2] && (r_s2_kind == KIND_BLEND), (w_sum[0][25:24] == 2'b00) && (w_sum[2][25:24] == 2'b00))

endmodule
